/* src/glsr_pkg.sv */
// ----------------------------------------------------------------------------
// glsr_pkg: shared definitions for the GF(2^8) secret recovery block
// Field arithmetic, configuration register indexes, sequencer state type and
// the status bundle passed from the coefficient unit to the top level.
// ----------------------------------------------------------------------------
package glsr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SHARE_W   = 64;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned STEP_W    = 3;

  // Low byte of the reducing polynomial x^8+x^4+x^3+x^2+1.
  localparam logic [BYTE_W-1:0] GF_POLY_LO = 8'h1D;
  // The inverse is taken as a^254.
  localparam logic [BYTE_W-1:0] INV_EXP    = 8'hFE;
  localparam logic [STEP_W-1:0] INV_LAST   = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_SHARE_COUNT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARE_POINTS = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROD,
    ST_INV,
    ST_FIN
  } glsr_state_e;

  typedef struct packed {
    logic busy;
    logic points_error;
  } coef_status_t;

  // Carry-less multiply with reduction, one bit of b per step.
  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] x;
    acc = '0;
    x   = a;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? GF_POLY_LO : '0);
    end
    return acc;
  endfunction

endpackage

/* src/glsr_cell.sv */
// ----------------------------------------------------------------------------
// glsr_cell: one lane of the recovery chain
// Multiplies its lane's share byte by the lane coefficient, adds it to the
// running sum from the previous cell and hands sum and shares onward.
// ----------------------------------------------------------------------------
module glsr_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic                                valid_i,
  input  logic [glsr_pkg::BYTE_W-1:0]         acc_i,
  input  logic [glsr_pkg::BYTE_W-1:0]         y_i,
  input  logic [glsr_pkg::BYTE_W-1:0]         coef_i,
  input  logic [glsr_pkg::SHARE_W-1:0]        shares_i,
  output logic                                valid_o,
  output logic [glsr_pkg::BYTE_W-1:0]         acc_o,
  output logic [glsr_pkg::SHARE_W-1:0]        shares_o
);

  logic                          valid_q;
  logic [glsr_pkg::BYTE_W-1:0]   acc_q, acc_d;
  logic [glsr_pkg::SHARE_W-1:0]  shares_q;

  assign acc_d = acc_i ^ glsr_pkg::gf_mul(y_i, coef_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      acc_q    <= acc_d;
      shares_q <= shares_i;
    end
  end

  assign valid_o  = valid_q;
  assign acc_o    = acc_q;
  assign shares_o = shares_q;

endmodule

/* src/glsr_coef_unit.sv */
// ----------------------------------------------------------------------------
// glsr_coef_unit: configuration registers and Lagrange coefficient sequencer
// Holds share count and points, and after each write to either recomputes every lane
// coefficient prod x_b / (x_a ^ x_b) with two shared field multipliers.
// ----------------------------------------------------------------------------
module glsr_coef_unit #(
  parameter int unsigned MAX_SHARES = 8
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           cfg_valid_i,
  input  logic [glsr_pkg::CFG_IDX_W-1:0]                 cfg_index_i,
  input  logic [glsr_pkg::SHARE_W-1:0]                   cfg_data_i,
  output logic [MAX_SHARES-1:0][glsr_pkg::BYTE_W-1:0]    coef_o,
  output glsr_pkg::coef_status_t                         status_o
);

  localparam int unsigned LW = $clog2(MAX_SHARES);
  localparam logic [LW-1:0] LAST_LANE = LW'(MAX_SHARES - 1);
  localparam logic [glsr_pkg::CNT_W-1:0] MAX_CNT = glsr_pkg::CNT_W'(MAX_SHARES);

  glsr_pkg::glsr_state_e state_q, state_d;

  logic [glsr_pkg::CNT_W-1:0]   count_q, count_d;
  logic [glsr_pkg::SHARE_W-1:0] points_q, points_d;
  logic [LW-1:0]                a_q, a_d, b_q, b_d;
  logic [glsr_pkg::STEP_W-1:0]  step_q, step_d;
  logic [glsr_pkg::BYTE_W-1:0]  num_q, num_d, den_q, den_d, r_q, r_d;
  logic                         dup_q, dup_d;
  logic [MAX_SHARES-1:0][glsr_pkg::BYTE_W-1:0] coef_q, coef_d;

  logic                         cfg_hit;
  logic [glsr_pkg::CNT_W-1:0]   k_eff;
  logic [glsr_pkg::BYTE_W-1:0]  xa, xb;
  logic                         a_used, b_used;
  logic [glsr_pkg::BYTE_W-1:0]  mul0_a, mul0_b, mul1_a, mul1_b, mul0_p, mul1_p;

  assign cfg_hit = cfg_valid_i && ((cfg_index_i == glsr_pkg::CFG_SHARE_COUNT) ||
                                   (cfg_index_i == glsr_pkg::CFG_SHARE_POINTS));

  always_comb begin
    if (count_q == '0) begin
      k_eff = glsr_pkg::CNT_W'(1);
    end else if (count_q > MAX_CNT) begin
      k_eff = MAX_CNT;
    end else begin
      k_eff = count_q;
    end
  end

  assign xa     = points_q[glsr_pkg::BYTE_W*a_q +: glsr_pkg::BYTE_W];
  assign xb     = points_q[glsr_pkg::BYTE_W*b_q +: glsr_pkg::BYTE_W];
  assign a_used = glsr_pkg::CNT_W'(a_q) < k_eff;
  assign b_used = glsr_pkg::CNT_W'(b_q) < k_eff;

  // Operand steering for the two shared multipliers.
  always_comb begin
    mul0_a = num_q;
    mul0_b = xb;
    mul1_a = den_q;
    mul1_b = xa ^ xb;
    unique case (state_q)
      glsr_pkg::ST_INV: begin
        mul0_a = r_q;
        mul0_b = den_q;
        mul1_a = den_q;
        mul1_b = den_q;
      end
      glsr_pkg::ST_FIN: begin
        mul0_a = num_q;
        mul0_b = r_q;
      end
      default: begin
      end
    endcase
  end

  assign mul0_p = glsr_pkg::gf_mul(mul0_a, mul0_b);
  assign mul1_p = glsr_pkg::gf_mul(mul1_a, mul1_b);

  // Next state.
  always_comb begin
    state_d = state_q;
    if (cfg_hit) begin
      state_d = glsr_pkg::ST_PROD;
    end else begin
      unique case (state_q)
        glsr_pkg::ST_IDLE: state_d = glsr_pkg::ST_IDLE;
        glsr_pkg::ST_PROD: if (b_q == LAST_LANE) state_d = glsr_pkg::ST_INV;
        glsr_pkg::ST_INV:  if (step_q == glsr_pkg::INV_LAST) state_d = glsr_pkg::ST_FIN;
        glsr_pkg::ST_FIN: begin
          state_d = (a_q == LAST_LANE) ? glsr_pkg::ST_IDLE : glsr_pkg::ST_PROD;
        end
        default: state_d = glsr_pkg::ST_IDLE;
      endcase
    end
  end

  // Datapath updates.
  always_comb begin
    count_d  = count_q;
    points_d = points_q;
    a_d      = a_q;
    b_d      = b_q;
    step_d   = step_q;
    num_d    = num_q;
    den_d    = den_q;
    r_d      = r_q;
    dup_d    = dup_q;
    coef_d   = coef_q;
    if (cfg_hit) begin
      if (cfg_index_i == glsr_pkg::CFG_SHARE_COUNT) begin
        count_d = cfg_data_i[glsr_pkg::CNT_W-1:0];
      end else begin
        points_d = cfg_data_i;
      end
      a_d   = '0;
      b_d   = '0;
      num_d = glsr_pkg::BYTE_W'(1);
      den_d = glsr_pkg::BYTE_W'(1);
      dup_d = 1'b0;
    end else begin
      unique case (state_q)
        glsr_pkg::ST_PROD: begin
          if ((b_q != a_q) && b_used) begin
            num_d = mul0_p;
            den_d = mul1_p;
            if (a_used && (xa == xb)) begin
              dup_d = 1'b1;
            end
          end
          b_d    = b_q + LW'(1);
          step_d = '0;
          r_d    = glsr_pkg::BYTE_W'(1);
        end
        glsr_pkg::ST_INV: begin
          // Square-and-multiply over the exponent bits, lowest first.
          if (glsr_pkg::INV_EXP[step_q]) begin
            r_d = mul0_p;
          end
          den_d  = mul1_p;
          step_d = step_q + glsr_pkg::STEP_W'(1);
        end
        glsr_pkg::ST_FIN: begin
          coef_d[a_q] = a_used ? mul0_p : '0;
          a_d   = a_q + LW'(1);
          b_d   = '0;
          num_d = glsr_pkg::BYTE_W'(1);
          den_d = glsr_pkg::BYTE_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= glsr_pkg::ST_IDLE;
      count_q  <= glsr_pkg::CNT_W'(1);
      points_q <= '0;
      dup_q    <= 1'b0;
      // Coefficients of the reset configuration: one lane, weight one.
      coef_q   <= (MAX_SHARES*glsr_pkg::BYTE_W)'(1);
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      points_q <= points_d;
      dup_q    <= dup_d;
      coef_q   <= coef_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    step_q <= step_d;
    num_q  <= num_d;
    den_q  <= den_d;
    r_q    <= r_d;
  end

  // Equal points zero every coefficient, so the chain sums to zero.
  always_comb begin
    for (int i = 0; i < MAX_SHARES; i++) begin
      coef_o[i] = dup_q ? '0 : coef_q[i];
    end
  end

  assign status_o.busy         = (state_q != glsr_pkg::ST_IDLE) || cfg_valid_i;
  assign status_o.points_error = dup_q;

endmodule

/* src/gf256_lagrange_secret_recover.sv */
// ----------------------------------------------------------------------------
// gf256_lagrange_secret_recover: Shamir secret byte recovery over GF(2^8)
//
// Write share_count (index 0) and share_points (index 1) on the cfg channel,
// which is always ready. Each write starts a recomputation of the lane
// coefficients with the shared multiplier pair of the coefficient unit;
// s_axis_tready_o stays low meanwhile. After reset the coefficients of the
// reset configuration are already in place and no recomputation runs.
// One s_axis transaction carries the eight share bytes of a pixel; one
// m_axis transaction returns the secret byte with the equal-points flag.
// The data path is a chain of MAX_SHARES registered cells, one per lane;
// while no recomputation runs and the receiver keeps up, one item is taken
// every cycle. When the receiver stalls, the last cell holds its result
// while earlier cells keep filling up to close any bubbles; input is
// refused only once the whole chain is full.
// ----------------------------------------------------------------------------
module gf256_lagrange_secret_recover #(
  parameter int unsigned MAX_SHARES = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [glsr_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [glsr_pkg::SHARE_W-1:0]           cfg_data_i,
  // Share stream.
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata: share_0 [7:0], share_1 [15:8], ... share_7 [63:56].
  input  logic [glsr_pkg::SHARE_W-1:0]           s_axis_tdata_i,
  // Secret stream.
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // tdata: secret_byte [7:0].
  output logic [glsr_pkg::BYTE_W-1:0]            m_axis_tdata_o,
  // tuser: points_error [0].
  output logic                                   m_axis_tuser_o
);

  logic [MAX_SHARES-1:0][glsr_pkg::BYTE_W-1:0] coef;
  glsr_pkg::coef_status_t                      status;

  logic [MAX_SHARES-1:0]        valid;
  logic [MAX_SHARES-1:0]        load;
  logic [glsr_pkg::BYTE_W-1:0]  acc    [MAX_SHARES];
  logic [glsr_pkg::SHARE_W-1:0] shares [MAX_SHARES];

  glsr_coef_unit #(
    .MAX_SHARES (MAX_SHARES)
  ) u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef),
    .status_o    (status)
  );

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = load[0] && !status.busy;

  for (genvar k = 0; k < MAX_SHARES; k++) begin : g_cell
    // A cell may take new data when it is empty or its successor moves on.
    if (k == MAX_SHARES - 1) begin : g_last
      assign load[k] = !valid[k] || m_axis_tready_i;
    end else begin : g_mid
      assign load[k] = !valid[k] || load[k+1];
    end

    if (k == 0) begin : g_head
      glsr_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .load_i   (load[k]),
        .valid_i  (s_axis_tvalid_i && s_axis_tready_o),
        .acc_i    ('0),
        .y_i      (s_axis_tdata_i[glsr_pkg::BYTE_W-1:0]),
        .coef_i   (coef[k]),
        .shares_i (s_axis_tdata_i),
        .valid_o  (valid[k]),
        .acc_o    (acc[k]),
        .shares_o (shares[k])
      );
    end else begin : g_body
      glsr_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .load_i   (load[k]),
        .valid_i  (valid[k-1]),
        .acc_i    (acc[k-1]),
        .y_i      (shares[k-1][glsr_pkg::BYTE_W*k +: glsr_pkg::BYTE_W]),
        .coef_i   (coef[k]),
        .shares_i (shares[k-1]),
        .valid_o  (valid[k]),
        .acc_o    (acc[k]),
        .shares_o (shares[k])
      );
    end
  end

  assign m_axis_tvalid_o = valid[MAX_SHARES-1];
  assign m_axis_tdata_o  = acc[MAX_SHARES-1];
  assign m_axis_tuser_o  = status.points_error;

endmodule
